/* sv/ppg_pkg.sv */
`timescale 1ns / 1ps
package ppg_pkg;
	localparam int AVG_WINDOW = 8;
	localparam int INTERVAL_WINDOW = 4;
	localparam int COUNT_WIDTH = 16;
	localparam int MIDX_W = $clog2(AVG_WINDOW);
	localparam int MFILL_W = $clog2(AVG_WINDOW + 1);
	localparam int IIDX_W = (INTERVAL_WINDOW > 1) ? $clog2(INTERVAL_WINDOW) : 1;
	localparam int IFILL_W = $clog2(INTERVAL_WINDOW + 1);
	localparam int ISUM_W = COUNT_WIDTH + IFILL_W;
	localparam int MSUM_W = 32 + MFILL_W;
	localparam int QDEPTH = 2;

	localparam logic signed [16:0] ALPHA_Q15 = 17'sd31130;
	localparam logic signed [16:0] LP_B_Q15 = 17'sd8036;
	localparam logic signed [16:0] LP_A_Q15 = 17'sd16696;

	localparam logic [1:0] REG_PRESENCE = 2'd0;
	localparam logic [1:0] REG_PEAK = 2'd1;
	localparam logic [1:0] REG_MAXRATE = 2'd2;
	localparam logic [1:0] REG_RATEK = 2'd3;

	typedef struct packed {
		logic [15:0] ir_sample;
		logic batch_first;
	} in_item_t;

	typedef struct packed {
		logic beat;
		logic [7:0] bpm;
		logic rate_updated;
		logic finger_present;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic present;
		logic [15:0] ir_sample;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DC, ST_LP1, ST_LP2, ST_MEAN, ST_DIV, ST_PEAK,
		ST_IDIV, ST_RDIV, ST_OUT
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// round to nearest, halves toward +inf: floor((p + 2^14) / 2^15)
	function automatic logic signed [63:0] rnd_q15(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd16384;
		return t >>> 15;
	endfunction
endpackage

/* sv/ppg_front.sv */
`timescale 1ns / 1ps
module ppg_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input ppg_pkg::in_item_t in_data,
	output logic in_stall,
	input logic [15:0] presence_threshold,
	output logic q_valid,
	output ppg_pkg::job_t q_data,
	input logic q_pop
);
	ppg_pkg::job_t mem_q [ppg_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic latch_q, push, lat_n;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign lat_n = in_data.batch_first ? (in_data.ir_sample > presence_threshold) : latch_q;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
			latch_q <= 1'b0;
		end else begin
			if (push) begin
				latch_q <= lat_n;
				wp_q <= ~wp_q;
			end
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{present: lat_n, ir_sample: in_data.ir_sample};
	end
endmodule

/* sv/ppg_div.sv */
`timescale 1ns / 1ps
module ppg_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [35:0] num,
	input logic [35:0] den,
	output logic done,
	output logic [35:0] quo
);
	// restoring divider, one quotient bit a cycle, unsigned
	logic [35:0] q_q, d_q;
	logic [36:0] r_q, trial;
	logic [5:0] n_q;
	logic busy_q;

	assign trial = {r_q[35:0], q_q[35]} - {1'b0, d_q};
	assign quo = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q <= 6'd36;
			end else if (busy_q) begin
				n_q <= n_q - 6'd1;
				if (n_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[36]) begin
				r_q <= trial;
				q_q <= {q_q[34:0], 1'b1};
			end else begin
				r_q <= {r_q[35:0], q_q[35]};
				q_q <= {q_q[34:0], 1'b0};
			end
		end
	end
endmodule

/* sv/ppg_back.sv */
`timescale 1ns / 1ps
module ppg_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input ppg_pkg::job_t q_data,
	output logic q_pop,
	input logic [15:0] peak_threshold,
	input logic [7:0] max_rate,
	input logic [15:0] rate_constant,
	output logic out_valid,
	output ppg_pkg::out_item_t out_data,
	input logic out_stall
);
	ppg_pkg::back_state_t st_q, st_n;
	logic [15:0] ir_q;
	logic signed [31:0] dc_q, lp_q, oldw_q, ac_q, v0_q, filt_q, level_q, pk_q, tmp_q;
	logic signed [31:0] mwin_q [ppg_pkg::AVG_WINDOW];
	logic signed [ppg_pkg::MSUM_W-1:0] msum_q;
	logic [ppg_pkg::MIDX_W-1:0] midx_q;
	logic [ppg_pkg::MFILL_W-1:0] mfill_q;
	logic wait_q, beat_q, upd_q;
	logic [ppg_pkg::COUNT_WIDTH-1:0] cnt_q, ppos_q, prev_q;
	logic [ppg_pkg::COUNT_WIDTH-1:0] istore_q [ppg_pkg::INTERVAL_WINDOW];
	logic [ppg_pkg::ISUM_W-1:0] isum_q;
	logic [ppg_pkg::IIDX_W-1:0] iidx_q;
	logic [ppg_pkg::IFILL_W-1:0] ifill_q;
	logic [7:0] hold_q;
	logic obuf_v_q;
	ppg_pkg::out_item_t obuf_q;
	logic dv_start, dv_done;
	logic [35:0] dv_num, dv_den, dv_quo;
	logic dv_neg_q;
	// presence of the item in flight
	logic wait_present_q;

	ppg_div u_div (.clk, .arst_n, .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_quo));

	logic signed [63:0] prod_a, prod_b;
	logic signed [ppg_pkg::MSUM_W-1:0] msum_n, msum_abs;
	logic [ppg_pkg::MFILL_W-1:0] mfill_n;
	logic [ppg_pkg::COUNT_WIDTH-1:0] ival;
	logic [ppg_pkg::ISUM_W-1:0] isum_n;
	logic [ppg_pkg::IFILL_W-1:0] ifill_n;
	logic pk_beat;
	logic signed [63:0] thr;
	logic signed [36:0] mean_s;

	assign thr = {40'd0, peak_threshold, 8'd0};
	assign out_valid = obuf_v_q;
	assign out_data = obuf_q;

	always_comb begin
		prod_a = 64'(dc_q) * 64'(ppg_pkg::ALPHA_Q15);
		prod_b = 64'(v0_q) * 64'(ppg_pkg::LP_A_Q15);
		if (st_q == ppg_pkg::ST_LP2) prod_a = -64'(ac_q) * 64'(ppg_pkg::LP_B_Q15);
		msum_n = msum_q - ((mfill_q >= ppg_pkg::MFILL_W'(ppg_pkg::AVG_WINDOW))
			? ppg_pkg::MSUM_W'(mwin_q[midx_q]) : '0) + ppg_pkg::MSUM_W'(filt_q);
		msum_abs = msum_n[ppg_pkg::MSUM_W-1] ? -msum_n : msum_n;
		mfill_n = (mfill_q < ppg_pkg::MFILL_W'(ppg_pkg::AVG_WINDOW))
			? mfill_q + 1'b1 : mfill_q;
		ival = ppos_q - prev_q;
		isum_n = isum_q - ((ifill_q >= ppg_pkg::IFILL_W'(ppg_pkg::INTERVAL_WINDOW))
			? ppg_pkg::ISUM_W'(istore_q[iidx_q]) : '0) + ppg_pkg::ISUM_W'(ival);
		ifill_n = (ifill_q < ppg_pkg::IFILL_W'(ppg_pkg::INTERVAL_WINDOW))
			? ifill_q + 1'b1 : ifill_q;
		pk_beat = (64'(level_q) > thr) && wait_q && (level_q < pk_q);
		mean_s = dv_neg_q ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
		dv_start = 1'b0;
		dv_num = 36'(msum_abs);
		dv_den = 36'(mfill_n);
		st_n = st_q;
		q_pop = 1'b0;
		case (st_q)
			ppg_pkg::ST_IDLE:
				if (q_valid && !obuf_v_q) begin
					q_pop = 1'b1;
					st_n = q_data.present ? ppg_pkg::ST_DC : ppg_pkg::ST_OUT;
				end
			ppg_pkg::ST_DC: st_n = ppg_pkg::ST_LP1;
			ppg_pkg::ST_LP1: st_n = ppg_pkg::ST_LP2;
			ppg_pkg::ST_LP2: st_n = ppg_pkg::ST_MEAN;
			ppg_pkg::ST_MEAN: begin
				dv_start = 1'b1;
				st_n = ppg_pkg::ST_DIV;
			end
			ppg_pkg::ST_DIV: if (dv_done) st_n = ppg_pkg::ST_PEAK;
			ppg_pkg::ST_PEAK:
				if (pk_beat) begin
					dv_start = 1'b1;
					dv_num = 36'(isum_n);
					dv_den = 36'(ifill_n);
					st_n = ppg_pkg::ST_IDIV;
				end else begin
					st_n = ppg_pkg::ST_OUT;
				end
			ppg_pkg::ST_IDIV:
				if (dv_done) begin
					if (dv_quo == '0) begin
						st_n = ppg_pkg::ST_OUT;
					end else begin
						dv_start = 1'b1;
						dv_num = 36'(rate_constant);
						dv_den = dv_quo;
						st_n = ppg_pkg::ST_RDIV;
					end
				end
			ppg_pkg::ST_RDIV: if (dv_done) st_n = ppg_pkg::ST_OUT;
			ppg_pkg::ST_OUT: st_n = ppg_pkg::ST_IDLE;
			default: st_n = ppg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ppg_pkg::ST_IDLE;
			dc_q <= '0; lp_q <= '0; msum_q <= '0; midx_q <= '0; mfill_q <= '0;
			wait_q <= 1'b1; pk_q <= '0; cnt_q <= '0; ppos_q <= '0; prev_q <= '0;
			isum_q <= '0; iidx_q <= '0; ifill_q <= '0; hold_q <= '0;
			obuf_v_q <= 1'b0; beat_q <= 1'b0; upd_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (obuf_v_q && !out_stall) obuf_v_q <= 1'b0;
			case (st_q)
				ppg_pkg::ST_IDLE: if (q_pop) begin
					ir_q <= q_data.ir_sample;
					beat_q <= 1'b0;
					upd_q <= 1'b0;
					if (!q_data.present) hold_q <= '0;
				end
				ppg_pkg::ST_DC: begin
					oldw_q <= dc_q;
					tmp_q <= ppg_pkg::sat32({40'd0, ir_q, 8'd0} + ppg_pkg::rnd_q15(prod_a));
					dc_q <= ppg_pkg::sat32({40'd0, ir_q, 8'd0} + ppg_pkg::rnd_q15(prod_a));
				end
				ppg_pkg::ST_LP1: begin
					ac_q <= ppg_pkg::sat32(64'(tmp_q) - 64'(oldw_q));
					v0_q <= lp_q;
				end
				ppg_pkg::ST_LP2: begin
					tmp_q <= ppg_pkg::sat32(ppg_pkg::rnd_q15(prod_a) + ppg_pkg::rnd_q15(prod_b));
					lp_q <= ppg_pkg::sat32(ppg_pkg::rnd_q15(prod_a) + ppg_pkg::rnd_q15(prod_b));
				end
				ppg_pkg::ST_MEAN: begin
					// window update, division by fill count follows
					if (mfill_q < ppg_pkg::MFILL_W'(ppg_pkg::AVG_WINDOW))
						mfill_q <= mfill_q + 1'b1;
					mwin_q[midx_q] <= filt_q;
					midx_q <= (midx_q == ppg_pkg::MIDX_W'(ppg_pkg::AVG_WINDOW - 1))
						? '0 : midx_q + 1'b1;
					msum_q <= msum_n;
				end
				ppg_pkg::ST_DIV: level_q <= ppg_pkg::sat32(64'(filt_q) - 64'(mean_s));
				ppg_pkg::ST_PEAK: begin
					cnt_q <= cnt_q + 1'b1;
					if (64'(level_q) > thr && wait_q) begin
						if (level_q > pk_q) begin
							pk_q <= level_q;
							ppos_q <= cnt_q;
						end else if (level_q < pk_q) begin
							beat_q <= 1'b1;
							pk_q <= '0;
							wait_q <= 1'b0;
							prev_q <= ppos_q;
							if (ifill_q < ppg_pkg::IFILL_W'(ppg_pkg::INTERVAL_WINDOW))
								ifill_q <= ifill_q + 1'b1;
							istore_q[iidx_q] <= ival;
							iidx_q <= (iidx_q == ppg_pkg::IIDX_W'(ppg_pkg::INTERVAL_WINDOW - 1))
								? '0 : iidx_q + 1'b1;
							isum_q <= isum_n;
						end
					end else if (64'(level_q) < thr) wait_q <= 1'b1;
				end
				ppg_pkg::ST_RDIV: if (dv_done && dv_quo < 36'(max_rate)) begin
					hold_q <= dv_quo[7:0];
					upd_q <= 1'b1;
				end
				ppg_pkg::ST_OUT: begin
					obuf_v_q <= 1'b1;
					obuf_q <= '{beat: beat_q, bpm: hold_q, rate_updated: upd_q,
						finger_present: wait_present_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wait_present_q <= 1'b0;
		else if (q_pop) wait_present_q <= q_data.present;
	end

	always_ff @(posedge clk) begin
		if (st_q == ppg_pkg::ST_LP2) filt_q <= ppg_pkg::sat32(64'(v0_q)
			+ 64'(ppg_pkg::sat32(ppg_pkg::rnd_q15(prod_a) + ppg_pkg::rnd_q15(prod_b))));
		if (st_q == ppg_pkg::ST_MEAN) dv_neg_q <= msum_n[ppg_pkg::MSUM_W-1];
		else if (st_q == ppg_pkg::ST_PEAK) dv_neg_q <= 1'b0;
	end
endmodule

/* sv/ppg_heart_rate_detector.sv */
`timescale 1ns / 1ps
// channel  | handshake          | payload
// in       | in_valid/in_stall  | in_data (ir_sample, batch_first)
// out      | out_valid/out_stall| out_data (beat, bpm, rate_updated, finger_present)
// cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data
// a present sample runs the DC, LP1, LP2, MEAN, PEAK and OUT states and the serial mean
// divider between one queue pop and the next; a beat adds the interval and rate divisions,
// the rate division skipped when the interval mean is zero; an absent sample goes to OUT
// a two-entry queue parts the front from the back; out_stall holds the result register
// reset is asynchronous, active low, and loads the register defaults
module ppg_heart_rate_detector (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input ppg_pkg::in_item_t in_data,
	output logic in_stall,
	output logic out_valid,
	output ppg_pkg::out_item_t out_data,
	input logic out_stall,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic [15:0] pres_q, peak_q, ratek_q;
	logic [7:0] maxr_q;
	logic q_valid, q_pop;
	ppg_pkg::job_t q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= 16'd10000;
			peak_q <= 16'd100;
			maxr_q <= 8'd200;
			ratek_q <= 16'd3000;
		end else if (cfg_valid) begin
			case (cfg_index)
				ppg_pkg::REG_PRESENCE: pres_q <= cfg_data;
				ppg_pkg::REG_PEAK: peak_q <= cfg_data;
				ppg_pkg::REG_MAXRATE: maxr_q <= cfg_data[7:0];
				ppg_pkg::REG_RATEK: ratek_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ppg_front u_front (.clk, .arst_n, .in_valid, .in_data, .in_stall,
		.presence_threshold(pres_q), .q_valid, .q_data, .q_pop);

	ppg_back u_back (.clk, .arst_n, .q_valid, .q_data, .q_pop,
		.peak_threshold(peak_q), .max_rate(maxr_q), .rate_constant(ratek_q),
		.out_valid, .out_data, .out_stall);
endmodule
